@@ rtl/cdi_pkg.sv @@
// Shared types, constants and helpers for the colour dictionary indexer.
package cdi_pkg;

    localparam int DEFAULT_ENTRIES = 256;
    localparam int MAX_ENTRIES     = 256;
    localparam int CHAN_W          = 8;
    localparam int KEEP_W          = 6;
    localparam int KEY_W           = 3 * KEEP_W;
    localparam int IDX_W           = 8;
    localparam int COUNT_W         = 9;

    typedef enum logic [1:0] {
        CMD_INDEX  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_IGNORE = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    // One request walking the chain of cells, picking up match and read data.
    typedef struct packed {
        logic             valid;
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] sel;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [KEY_W-1:0] color;
    } t_token;

    // Broadcast write of a new colour into one cell.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] key;
    } t_wr;

    function automatic logic [KEY_W-1:0] reduce_key(
        input logic [CHAN_W-1:0] r,
        input logic [CHAN_W-1:0] g,
        input logic [CHAN_W-1:0] b
    );
        reduce_key = {r[CHAN_W-1 -: KEEP_W], g[CHAN_W-1 -: KEEP_W], b[CHAN_W-1 -: KEEP_W]};
    endfunction

    function automatic logic [CHAN_W-1:0] expand_chan(input logic [KEEP_W-1:0] c);
        expand_chan = {c, {(CHAN_W - KEEP_W){1'b0}}};
    endfunction

endpackage

@@ rtl/cdi_cell.sv @@
// One palette entry: holds a colour and updates the request token passing by.
module cdi_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdi_pkg::t_token    i_tok,
    input  logic [CNT_W-1:0]   i_count,
    input  cdi_pkg::t_wr       i_wr,
    output cdi_pkg::t_token    o_tok
);

    logic [cdi_pkg::KEY_W-1:0] r_color;
    cdi_pkg::t_token           r_tok;
    cdi_pkg::t_token           n_tok;
    logic                      w_active;

    // Only entries below the fill count are visible.
    assign w_active = CNT_W'(CELL_IDX) < i_count;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && w_active) begin
            if (i_tok.cmd == cdi_pkg::CMD_INDEX && !i_tok.hit && r_color == i_tok.key) begin
                n_tok.hit     = 1'b1;
                n_tok.hit_idx = cdi_pkg::IDX_W'(CELL_IDX);
            end
            if (i_tok.cmd == cdi_pkg::CMD_READ && i_tok.sel == cdi_pkg::IDX_W'(CELL_IDX)) begin
                n_tok.color = r_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.addr == cdi_pkg::IDX_W'(CELL_IDX)) begin
            r_color <= i_wr.key;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/cdi_ctrl.sv @@
// Sequencer: launches a request into the chain, resolves it at the tail, keeps the count.
module cdi_ctrl #(
    parameter int TABLE_ENTRIES = cdi_pkg::DEFAULT_ENTRIES,
    parameter int CNT_W         = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [cdi_pkg::CHAN_W-1:0]  i_red_in,
    input  logic [cdi_pkg::CHAN_W-1:0]  i_green_in,
    input  logic [cdi_pkg::CHAN_W-1:0]  i_blue_in,
    input  logic [cdi_pkg::IDX_W-1:0]   i_entry_select,
    output cdi_pkg::t_token             o_head,
    input  cdi_pkg::t_token             i_tail,
    output cdi_pkg::t_wr                o_wr,
    output logic [CNT_W-1:0]            o_count,
    output logic                        o_strobe,
    output logic [cdi_pkg::IDX_W-1:0]   o_color_index,
    output logic                        o_is_new,
    output logic                        o_overflow,
    output logic [cdi_pkg::CHAN_W-1:0]  o_pal_red,
    output logic [cdi_pkg::CHAN_W-1:0]  o_pal_green,
    output logic [cdi_pkg::CHAN_W-1:0]  o_pal_blue,
    output logic [cdi_pkg::COUNT_W-1:0] o_color_count
);

    localparam int KW = cdi_pkg::KEEP_W;

    cdi_pkg::t_state             r_state, n_state;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_strobe;
    logic [cdi_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic                        r_new, n_new;
    logic                        r_ovf, n_ovf;
    logic [cdi_pkg::KEY_W-1:0]   r_pal, n_pal;
    logic                        w_accept;
    logic                        w_done;
    logic                        w_room;

    assign w_accept = start && !busy;
    assign w_done   = (r_state == cdi_pkg::ST_SEARCH) && i_tail.valid;
    assign w_room   = r_count < CNT_W'(TABLE_ENTRIES);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdi_pkg::ST_IDLE: begin
                if (start) n_state = cdi_pkg::ST_SEARCH;
            end
            cdi_pkg::ST_SEARCH: begin
                if (i_tail.valid) n_state = cdi_pkg::ST_IDLE;
            end
            default: n_state = cdi_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        unique case (r_state)
            cdi_pkg::ST_IDLE:   busy = 1'b0;
            cdi_pkg::ST_SEARCH: busy = 1'b1;
            default:            busy = 1'b1;
        endcase
    end

    always_comb begin
        o_head         = '0;
        o_head.valid   = w_accept;
        o_head.cmd     = cdi_pkg::t_cmd'(i_command);
        o_head.key     = cdi_pkg::reduce_key(i_red_in, i_green_in, i_blue_in);
        o_head.sel     = i_entry_select;
    end

    // Resolve the beat once the token leaves the last cell.
    always_comb begin
        n_count = r_count;
        n_idx   = '0;
        n_new   = 1'b0;
        n_ovf   = 1'b0;
        n_pal   = '0;
        o_wr    = '0;
        o_wr.addr = cdi_pkg::IDX_W'(r_count);
        o_wr.key  = i_tail.key;
        if (w_done) begin
            case (i_tail.cmd)
                cdi_pkg::CMD_INDEX: begin
                    if (i_tail.hit) begin
                        n_idx = i_tail.hit_idx;
                    end else if (w_room) begin
                        n_idx   = cdi_pkg::IDX_W'(r_count);
                        n_new   = 1'b1;
                        o_wr.en = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                cdi_pkg::CMD_READ: begin
                    n_idx = i_tail.sel;
                    n_pal = i_tail.color;
                end
                cdi_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cdi_pkg::ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_idx <= n_idx;
            r_new <= n_new;
            r_ovf <= n_ovf;
            r_pal <= n_pal;
        end
    end

    assign o_count       = r_count;
    assign o_strobe      = r_strobe;
    assign o_color_index = r_idx;
    assign o_is_new      = r_new;
    assign o_overflow    = r_ovf;
    assign o_pal_red     = cdi_pkg::expand_chan(r_pal[3*KW-1 -: KW]);
    assign o_pal_green   = cdi_pkg::expand_chan(r_pal[2*KW-1 -: KW]);
    assign o_pal_blue    = cdi_pkg::expand_chan(r_pal[KW-1:0]);
    assign o_color_count = cdi_pkg::COUNT_W'(r_count);

endmodule

@@ rtl/color_dictionary_indexer_core.sv @@
// Top level: sequencer plus a chain of TABLE_ENTRIES palette cells.
// The request token walks the cell chain one cell per cycle, and busy stays high until
// it leaves the last cell: a new request is taken only once the last one is resolved.
// Reset clears the sequencer, the colour count and the chain's tokens; stored colours
// are not cleared. The receiver cannot stall: each result is shown for one cycle.
module color_dictionary_indexer_core #(
    parameter int TABLE_ENTRIES = cdi_pkg::DEFAULT_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [cdi_pkg::CHAN_W-1:0]  i_red_in,
    input  logic [cdi_pkg::CHAN_W-1:0]  i_green_in,
    input  logic [cdi_pkg::CHAN_W-1:0]  i_blue_in,
    input  logic [cdi_pkg::IDX_W-1:0]   i_entry_select,
    output logic                        o_strobe,
    output logic [cdi_pkg::IDX_W-1:0]   o_color_index,
    output logic                        o_is_new,
    output logic                        o_overflow,
    output logic [cdi_pkg::CHAN_W-1:0]  o_pal_red,
    output logic [cdi_pkg::CHAN_W-1:0]  o_pal_green,
    output logic [cdi_pkg::CHAN_W-1:0]  o_pal_blue,
    output logic [cdi_pkg::COUNT_W-1:0] o_color_count
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    cdi_pkg::t_token    w_tok [TABLE_ENTRIES+1];
    cdi_pkg::t_wr       w_wr;
    logic [CNT_W-1:0]   w_count;

    cdi_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_red_in       (i_red_in),
        .i_green_in     (i_green_in),
        .i_blue_in      (i_blue_in),
        .i_entry_select (i_entry_select),
        .o_head         (w_tok[0]),
        .i_tail         (w_tok[TABLE_ENTRIES]),
        .o_wr           (w_wr),
        .o_count        (w_count),
        .o_strobe       (o_strobe),
        .o_color_index  (o_color_index),
        .o_is_new       (o_is_new),
        .o_overflow     (o_overflow),
        .o_pal_red      (o_pal_red),
        .o_pal_green    (o_pal_green),
        .o_pal_blue     (o_pal_blue),
        .o_color_count  (o_color_count)
    );

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
        cdi_cell #(
            .CELL_IDX (gi),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[gi]),
            .i_count (w_count),
            .i_wr    (w_wr),
            .o_tok   (w_tok[gi+1])
        );
    end

endmodule
